@@ design/toc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and slot arithmetic for the timestamp-ordered ring cache.
// Depends on nothing; used by timestamp_ordered_ring_cache and tb_top.
package toc_pkg;

    localparam int CAPACITY = 64;
    localparam int LEVELS   = 8;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LI_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SEEN_W   = $clog2(LEVELS + 1);
    localparam int TS_W     = 32;
    localparam int RLVL_W   = 3;
    localparam int DATA_W   = 64;
    localparam int CFG_W    = 7;

    typedef struct packed {
        logic [TS_W-1:0]   stamp;
        logic [RLVL_W-1:0] lvl;
        logic [DATA_W-1:0] data;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        OP_FEED   = 3'd0,
        OP_UPDATE = 3'd1,
        OP_LATEST = 3'd2,
        OP_RANGE  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NONRISE  = 3'd1,
        ST_DELAY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_BADLVL   = 3'd5,
        ST_RANGE    = 3'd6
    } status_t;

    typedef enum logic {
        CFG_MAX_ENTRIES = 1'b0,
        CFG_EVICT_MIN   = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FEED_NEWEST,
        S_FEED_OLDEST,
        S_FEED_WRITE,
        S_UPD_ISSUE,
        S_UPD_CMP,
        S_UPD_TRACK,
        S_UPD_TCMP,
        S_REC_OUT,
        S_DONE
    } state_t;

    // Slot of the record at offset off from base, wrapping around the ring.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(CAPACITY))
            sum = sum - (CNT_W + 1)'(CAPACITY);
        return sum[SLOT_W-1:0];
    endfunction

    // Position from the oldest record of a given slot.
    function automatic logic [CNT_W-1:0] pos_of(input logic [SLOT_W-1:0] slot,
                                                input logic [SLOT_W-1:0] oldest);
        logic [CNT_W:0] diff;
        diff = {{(CNT_W + 1 - SLOT_W){1'b0}}, slot} + (CNT_W + 1)'(CAPACITY)
             - {{(CNT_W + 1 - SLOT_W){1'b0}}, oldest};
        if (diff >= (CNT_W + 1)'(CAPACITY))
            diff = diff - (CNT_W + 1)'(CAPACITY);
        return diff[CNT_W-1:0];
    endfunction

endpackage

@@ design/toc_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module toc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/timestamp_ordered_ring_cache.sv @@
`timescale 1ns / 1ps
// Top level of the timestamp-ordered ring cache: sequencer, level marks, output register.
// Depends on toc_pkg and toc_ram.
//
// The cache keeps records (timestamp, level, payload) in a ring of CAPACITY slots held
// in one record RAM with a single read port and registered read data. Every RAM access
// goes through that one port under a small sequencer, so the block takes one request at
// a time: in_ready is high only while the sequencer idles. Read entry, latest at level and
// level range read one record after decode. Feed writes straight away on an empty cache,
// reads the newest record first when not full and the oldest one too when it evicts;
// update reads and compares once per binary-search probe (at most log2(count)+1 probes,
// 7 for 64 records) and adds a timestamp compare when the level mark needs one. Error
// results for a bad level, an empty cache, an out-of-range read or an unknown operation
// leave straight from decode, a non-rising feed after the newest read, an analysis delay
// after the oldest read and an absent update after its probes. The output register
// frees the sequencer once loaded; a result that cannot be loaded because the previous
// one is still held stalls the sequencer. There is no clearing pass after reset: stores
// are only read at slots that hold live records. Configuration writes are taken at any
// cycle and must only happen while the block is idle.
module timestamp_ordered_ring_cache (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [toc_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  operation,
    input  logic [31:0]                 timestamp,
    input  logic [7:0]                  level,
    input  logic [63:0]                 payload,
    input  logic [5:0]                  position,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [6:0]                  start_position,
    output logic [6:0]                  end_position,
    output logic [31:0]                 out_timestamp,
    output logic [2:0]                  out_level,
    output logic [63:0]                 out_payload
);

    localparam int SW = toc_pkg::SLOT_W;
    localparam int CW = toc_pkg::CNT_W;
    localparam int LW = toc_pkg::LI_W;
    localparam int NL = toc_pkg::LEVELS;

    toc_pkg::state_t state_reg, state_next;

    // Latched request
    logic [2:0]                op_reg, op_next;
    logic [31:0]               ts_reg, ts_next;
    logic [7:0]                lvl_reg, lvl_next;
    logic [63:0]               pay_reg, pay_next;
    logic [5:0]                pos_reg, pos_next;

    // Ring and level marks
    logic [SW-1:0]             oldest_reg, oldest_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [NL-1:0]             lat_valid_reg, lat_valid_next;
    logic [SW-1:0]             lat_slot_reg [NL];
    logic [SW-1:0]             lat_slot_next [NL];
    logic [toc_pkg::SEEN_W-1:0] seen_reg, seen_next;

    // Configuration
    logic [toc_pkg::CFG_W-1:0] max_reg, max_next;
    logic [2:0]                emin_reg, emin_next;

    // Binary search
    logic [CW-1:0]             lo_reg, lo_next;
    logic [CW-1:0]             hi_reg, hi_next;
    logic [CW-1:0]             mid_reg, mid_next;
    logic [SW-1:0]             slot_reg, slot_next;

    // Pending result
    logic [2:0]                res_status_reg, res_status_next;
    logic [6:0]                res_start_reg, res_start_next;
    logic [6:0]                res_end_reg, res_end_next;
    logic [31:0]               res_ts_reg, res_ts_next;
    logic [2:0]                res_lvl_reg, res_lvl_next;
    logic [63:0]               res_pay_reg, res_pay_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [2:0]                status_reg, status_next;
    logic [6:0]                start_reg, start_next;
    logic [6:0]                end_reg, end_next;
    logic [31:0]               ots_reg, ots_next;
    logic [2:0]                olvl_reg, olvl_next;
    logic [63:0]               opay_reg, opay_next;

    // RAM port
    logic                      ram_we;
    logic [SW-1:0]             ram_waddr;
    toc_pkg::rec_t             ram_wdata;
    logic [SW-1:0]             ram_raddr;
    toc_pkg::rec_t             ram_rdata;
    logic [toc_pkg::REC_W-1:0] ram_rbits;

    assign ram_rdata = toc_pkg::rec_t'(ram_rbits);

    toc_ram #(
        .WIDTH (toc_pkg::REC_W),
        .DEPTH (toc_pkg::CAPACITY)
    ) u_rec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    // Effective entry limit: zero acts as one, clip at capacity
    logic [CW-1:0] limit;
    always_comb
    begin
        if (max_reg == '0)
            limit = CW'(1);
        else if (int'(max_reg) > toc_pkg::CAPACITY)
            limit = CW'(toc_pkg::CAPACITY);
        else
            limit = CW'(max_reg);
    end

    logic [LW-1:0] li;
    logic [LW-1:0] li_nxt;
    logic          lvl_bad;
    logic          qlvl_bad;
    logic          nxt_ok;
    logic [CW-1:0] q_end;
    logic [CW-1:0] q_start;
    logic [CW:0]   mid_sum;

    assign li      = lvl_reg[LW-1:0];
    assign li_nxt  = li + LW'(1);
    assign lvl_bad = (int'(lvl_reg) >= NL);
    assign qlvl_bad = lvl_bad || (int'(lvl_reg) >= int'(seen_reg));
    assign nxt_ok  = (int'(lvl_reg) + 1 < int'(seen_reg)) && (int'(lvl_reg) + 1 < NL)
                     && lat_valid_reg[li_nxt];
    assign q_end   = toc_pkg::pos_of(lat_slot_reg[li], oldest_reg) + CW'(1);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW + 1)'(1);

    always_comb
    begin
        q_start = '0;
        if (nxt_ok)
        begin
            q_start = toc_pkg::pos_of(lat_slot_reg[li_nxt], oldest_reg) + CW'(1);
        end
        if (q_start > q_end)
        begin
            q_start = q_end;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ts_next         = ts_reg;
        lvl_next        = lvl_reg;
        pay_next        = pay_reg;
        pos_next        = pos_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        lat_valid_next  = lat_valid_reg;
        lat_slot_next   = lat_slot_reg;
        seen_next       = seen_reg;
        max_next        = max_reg;
        emin_next       = emin_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        res_ts_next     = res_ts_reg;
        res_lvl_next    = res_lvl_reg;
        res_pay_next    = res_pay_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        ots_next        = ots_reg;
        olvl_next       = olvl_reg;
        opay_next       = opay_reg;
        ram_we          = 1'b0;
        ram_waddr       = toc_pkg::slot_add(oldest_reg, count_reg);
        ram_wdata       = '{stamp: ts_reg, lvl: lvl_reg[2:0], data: pay_reg};
        ram_raddr       = oldest_reg;
        in_ready        = (state_reg == toc_pkg::S_IDLE);

        // Drop the output once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                toc_pkg::CFG_MAX_ENTRIES: max_next  = cfg_data;
                toc_pkg::CFG_EVICT_MIN:   emin_next = cfg_data[2:0];
                default:                  max_next  = max_reg;
            endcase
        end

        case (state_reg)
            toc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    ts_next    = timestamp;
                    lvl_next   = level;
                    pay_next   = payload;
                    pos_next   = position;
                    state_next = toc_pkg::S_DECODE;
                end
            end

            toc_pkg::S_DECODE:
            begin
                // Clear the result; later steps fill in what applies
                res_status_next = toc_pkg::ST_OK;
                res_start_next  = '0;
                res_end_next    = '0;
                res_ts_next     = '0;
                res_lvl_next    = '0;
                res_pay_next    = '0;
                state_next      = toc_pkg::S_DONE;
                case (op_reg)
                    toc_pkg::OP_FEED:
                    begin
                        if (lvl_bad)
                            res_status_next = toc_pkg::ST_BADLVL;
                        else if (count_reg == '0)
                            state_next = toc_pkg::S_FEED_WRITE;
                        else
                        begin
                            ram_raddr  = toc_pkg::slot_add(oldest_reg, count_reg - CW'(1));
                            state_next = toc_pkg::S_FEED_NEWEST;
                        end
                    end
                    toc_pkg::OP_UPDATE:
                    begin
                        if (lvl_bad)
                            res_status_next = toc_pkg::ST_BADLVL;
                        else if (count_reg == '0)
                            res_status_next = toc_pkg::ST_EMPTY;
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = toc_pkg::S_UPD_ISSUE;
                        end
                    end
                    toc_pkg::OP_LATEST, toc_pkg::OP_RANGE:
                    begin
                        if (qlvl_bad)
                            res_status_next = toc_pkg::ST_BADLVL;
                        else if (!lat_valid_reg[li])
                            res_status_next = toc_pkg::ST_NOTFOUND;
                        else
                        begin
                            ram_raddr = lat_slot_reg[li];
                            if (op_reg == toc_pkg::OP_LATEST)
                            begin
                                res_start_next = 7'(q_end - CW'(1));
                            end
                            else
                            begin
                                res_start_next = 7'(q_start);
                                res_end_next   = 7'(q_end);
                            end
                            state_next = toc_pkg::S_REC_OUT;
                        end
                    end
                    toc_pkg::OP_READ:
                    begin
                        if (count_reg == '0)
                            res_status_next = toc_pkg::ST_EMPTY;
                        else if (int'(pos_reg) >= int'(count_reg))
                            res_status_next = toc_pkg::ST_RANGE;
                        else
                        begin
                            ram_raddr      = toc_pkg::slot_add(oldest_reg, CW'(pos_reg));
                            res_start_next = 7'(pos_reg);
                            state_next     = toc_pkg::S_REC_OUT;
                        end
                    end
                    default:
                    begin
                        res_status_next = toc_pkg::ST_RANGE;
                    end
                endcase
            end

            toc_pkg::S_FEED_NEWEST:
            begin
                if (ts_reg <= ram_rdata.stamp)
                begin
                    res_status_next = toc_pkg::ST_NONRISE;
                    state_next      = toc_pkg::S_DONE;
                end
                else if (count_reg >= limit)
                begin
                    ram_raddr  = oldest_reg;
                    state_next = toc_pkg::S_FEED_OLDEST;
                end
                else
                begin
                    state_next = toc_pkg::S_FEED_WRITE;
                end
            end

            toc_pkg::S_FEED_OLDEST:
            begin
                if (ram_rdata.lvl < emin_reg)
                begin
                    res_status_next = toc_pkg::ST_DELAY;
                    state_next      = toc_pkg::S_DONE;
                end
                else
                begin
                    // Evict: drop marks on the oldest slot and advance
                    for (int i = 0; i < NL; i++)
                    begin
                        if (lat_valid_reg[i] && lat_slot_reg[i] == oldest_reg)
                            lat_valid_next[i] = 1'b0;
                    end
                    oldest_next = toc_pkg::slot_add(oldest_reg, CW'(1));
                    count_next  = count_reg - CW'(1);
                    state_next  = toc_pkg::S_FEED_WRITE;
                end
            end

            toc_pkg::S_FEED_WRITE:
            begin
                // New stamp is above every live one, so the mark always moves here
                ram_we             = 1'b1;
                count_next         = count_reg + CW'(1);
                lat_valid_next[li] = 1'b1;
                lat_slot_next[li]  = ram_waddr;
                if (int'(lvl_reg) + 1 > int'(seen_reg))
                    seen_next = toc_pkg::SEEN_W'(int'(lvl_reg) + 1);
                res_start_next = 7'(count_reg);
                res_ts_next    = ts_reg;
                res_lvl_next   = lvl_reg[2:0];
                res_pay_next   = pay_reg;
                state_next     = toc_pkg::S_DONE;
            end

            toc_pkg::S_UPD_ISSUE:
            begin
                if (lo_reg >= hi_reg)
                begin
                    res_status_next = toc_pkg::ST_NOTFOUND;
                    state_next      = toc_pkg::S_DONE;
                end
                else
                begin
                    mid_next   = mid_sum[CW:1];
                    ram_raddr  = toc_pkg::slot_add(oldest_reg, mid_sum[CW:1]);
                    state_next = toc_pkg::S_UPD_CMP;
                end
            end

            toc_pkg::S_UPD_CMP:
            begin
                if (ram_rdata.stamp == ts_reg)
                begin
                    slot_next = toc_pkg::slot_add(oldest_reg, mid_reg);
                    ram_we    = 1'b1;
                    ram_waddr = toc_pkg::slot_add(oldest_reg, mid_reg);
                    for (int i = 0; i < NL; i++)
                    begin
                        if (lat_valid_reg[i] &&
                            lat_slot_reg[i] == toc_pkg::slot_add(oldest_reg, mid_reg))
                            lat_valid_next[i] = 1'b0;
                    end
                    res_start_next = 7'(mid_reg);
                    res_ts_next    = ts_reg;
                    res_lvl_next   = lvl_reg[2:0];
                    res_pay_next   = pay_reg;
                    state_next     = toc_pkg::S_UPD_TRACK;
                end
                else
                begin
                    if (ram_rdata.stamp > ts_reg)
                        hi_next = mid_reg;
                    else
                        lo_next = mid_reg + CW'(1);
                    state_next = toc_pkg::S_UPD_ISSUE;
                end
            end

            toc_pkg::S_UPD_TRACK:
            begin
                if (int'(lvl_reg) + 1 > int'(seen_reg))
                    seen_next = toc_pkg::SEEN_W'(int'(lvl_reg) + 1);
                if (lat_valid_reg[li])
                begin
                    ram_raddr  = lat_slot_reg[li];
                    state_next = toc_pkg::S_UPD_TCMP;
                end
                else
                begin
                    lat_valid_next[li] = 1'b1;
                    lat_slot_next[li]  = slot_reg;
                    state_next         = toc_pkg::S_DONE;
                end
            end

            toc_pkg::S_UPD_TCMP:
            begin
                if (ram_rdata.stamp <= ts_reg)
                begin
                    lat_slot_next[li] = slot_reg;
                end
                state_next = toc_pkg::S_DONE;
            end

            toc_pkg::S_REC_OUT:
            begin
                res_ts_next  = ram_rdata.stamp;
                res_lvl_next = ram_rdata.lvl;
                res_pay_next = ram_rdata.data;
                state_next   = toc_pkg::S_DONE;
            end

            toc_pkg::S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    start_next     = res_start_reg;
                    end_next       = res_end_reg;
                    ots_next       = res_ts_reg;
                    olvl_next      = res_lvl_reg;
                    opay_next      = res_pay_reg;
                    state_next     = toc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = toc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= toc_pkg::S_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            lat_valid_reg <= '0;
            for (int i = 0; i < NL; i++)
            begin
                lat_slot_reg[i] <= '0;
            end
            seen_reg      <= '0;
            max_reg       <= toc_pkg::CFG_W'(64);
            emin_reg      <= 3'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            lat_valid_reg <= lat_valid_next;
            lat_slot_reg  <= lat_slot_next;
            seen_reg      <= seen_next;
            max_reg       <= max_next;
            emin_reg      <= emin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        ts_reg         <= ts_next;
        lvl_reg        <= lvl_next;
        pay_reg        <= pay_next;
        pos_reg        <= pos_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        res_ts_reg     <= res_ts_next;
        res_lvl_reg    <= res_lvl_next;
        res_pay_reg    <= res_pay_next;
        status_reg     <= status_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        ots_reg        <= ots_next;
        olvl_reg       <= olvl_next;
        opay_reg       <= opay_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign start_position = start_reg;
    assign end_position   = end_reg;
    assign out_timestamp  = ots_reg;
    assign out_level      = olvl_reg;
    assign out_payload    = opay_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for timestamp_ordered_ring_cache: directed and random requests.
// Depends on toc_pkg and the cache RTL; holds its own behavioral predictor.
module tb_top;

    // Operation codes the block does not know
    localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_LAST  = 3'd7;

    // Entry limit and eviction level for the first configuration phases
    localparam int unsigned ME_SET [5] = '{64, 1, 127, 5, 0};
    localparam int unsigned ML_SET [5] = '{1, 0, 3, 7, 2};

    // Predictor of the cache plus the queue of results still owed by the block.
    class cache_scoreboard;
        logic [31:0] stamps [toc_pkg::CAPACITY];
        logic [2:0]  lvls [toc_pkg::CAPACITY];
        logic [63:0] datas [toc_pkg::CAPACITY];
        int unsigned oldest, count, seen;
        bit          mark_ok [toc_pkg::LEVELS];
        int unsigned mark_slot [toc_pkg::LEVELS];
        int unsigned max_ent, min_lvl;
        logic [115:0] owed [$];
        int errors;

        function void clear();
            oldest = 0; count = 0; seen = 0; max_ent = 64; min_lvl = 1;
            foreach (mark_ok[i])
            begin
                mark_ok[i] = 0;
                mark_slot[i] = 0;
            end
            errors = 0;
        endfunction

        function int unsigned slot_at(int unsigned p);
            return (oldest + p) % toc_pkg::CAPACITY;
        endfunction

        function int unsigned place_of(int unsigned s);
            return (s + toc_pkg::CAPACITY - oldest) % toc_pkg::CAPACITY;
        endfunction

        function void push(toc_pkg::status_t st, int unsigned sp, int unsigned ep, bit rec,
                           int unsigned s);
            owed.insert(owed.size(), {st, 7'(sp), 7'(ep), rec ? stamps[s] : 32'd0,
                                      rec ? lvls[s] : 3'd0, rec ? datas[s] : 64'd0});
        endfunction

        function void unmark(int unsigned s);
            for (int i = 0; i < toc_pkg::LEVELS; i++)
                if (mark_ok[i] && mark_slot[i] == s) mark_ok[i] = 0;
        endfunction

        function void mark(int unsigned l, int unsigned s);
            if (l + 1 > seen) seen = l + 1;
            if (!mark_ok[l] || stamps[mark_slot[l]] <= stamps[s])
            begin
                mark_ok[l] = 1;
                mark_slot[l] = s;
            end
        endfunction

        // Note one accepted request and queue its expected result.
        function void note_request(logic [2:0] op, logic [31:0] ts, logic [7:0] lv,
                                   logic [63:0] pay, logic [5:0] pos);
            int unsigned lim, s, e, b;
            int lo, hi, mid;
            lim = (max_ent == 0) ? 1
                : (max_ent > toc_pkg::CAPACITY ? toc_pkg::CAPACITY : max_ent);
            case (op)
                toc_pkg::OP_FEED:
                begin
                    if (lv >= toc_pkg::LEVELS)
                    begin
                        push(toc_pkg::ST_BADLVL, 0, 0, 0, 0);
                        return;
                    end
                    if (count > 0)
                    begin
                        if (ts <= stamps[slot_at(count - 1)])
                        begin
                            push(toc_pkg::ST_NONRISE, 0, 0, 0, 0);
                            return;
                        end
                        if (count >= lim)
                        begin
                            if (lvls[oldest] < min_lvl)
                            begin
                                push(toc_pkg::ST_DELAY, 0, 0, 0, 0);
                                return;
                            end
                            unmark(oldest);
                            oldest = (oldest + 1) % toc_pkg::CAPACITY;
                            count--;
                        end
                    end
                    s = slot_at(count);
                    stamps[s] = ts; lvls[s] = lv[2:0]; datas[s] = pay;
                    count++;
                    mark(lv, s);
                    push(toc_pkg::ST_OK, count - 1, 0, 1, s);
                end
                toc_pkg::OP_UPDATE:
                begin
                    if (lv >= toc_pkg::LEVELS)
                    begin
                        push(toc_pkg::ST_BADLVL, 0, 0, 0, 0);
                        return;
                    end
                    if (count == 0)
                    begin
                        push(toc_pkg::ST_EMPTY, 0, 0, 0, 0);
                        return;
                    end
                    lo = 0; hi = count - 1;
                    while (lo <= hi)
                    begin
                        mid = (lo + hi) / 2;
                        s = slot_at(mid);
                        if (stamps[s] == ts)
                        begin
                            lvls[s] = lv[2:0]; datas[s] = pay;
                            unmark(s); mark(lv, s);
                            push(toc_pkg::ST_OK, mid, 0, 1, s);
                            return;
                        end
                        if (stamps[s] > ts) hi = mid - 1; else lo = mid + 1;
                    end
                    push(toc_pkg::ST_NOTFOUND, 0, 0, 0, 0);
                end
                toc_pkg::OP_LATEST, toc_pkg::OP_RANGE:
                begin
                    if (lv >= seen || lv >= toc_pkg::LEVELS)
                    begin
                        push(toc_pkg::ST_BADLVL, 0, 0, 0, 0);
                        return;
                    end
                    if (!mark_ok[lv])
                    begin
                        push(toc_pkg::ST_NOTFOUND, 0, 0, 0, 0);
                        return;
                    end
                    s = mark_slot[lv];
                    if (op == toc_pkg::OP_LATEST)
                    begin
                        push(toc_pkg::ST_OK, place_of(s), 0, 1, s);
                        return;
                    end
                    e = place_of(s) + 1; b = 0;
                    if (lv + 1 < seen && lv + 1 < toc_pkg::LEVELS && mark_ok[lv + 1])
                        b = place_of(mark_slot[lv + 1]) + 1;
                    if (b > e) b = e;
                    push(toc_pkg::ST_OK, b, e, 1, s);
                end
                toc_pkg::OP_READ:
                begin
                    if (count == 0) push(toc_pkg::ST_EMPTY, 0, 0, 0, 0);
                    else if (pos >= count) push(toc_pkg::ST_RANGE, 0, 0, 0, 0);
                    else push(toc_pkg::ST_OK, pos, 0, 1, slot_at(pos));
                end
                default: push(toc_pkg::ST_RANGE, 0, 0, 0, 0);
            endcase
        endfunction

        // Compare one accepted result against the oldest expectation.
        function void check_result(logic [2:0] st, logic [6:0] sp, logic [6:0] ep,
                                   logic [31:0] ts, logic [2:0] lv, logic [63:0] pay);
            logic [115:0] w;
            if (owed.size() == 0)
            begin
                $error("unexpected result status=%0d", st);
                errors++;
                return;
            end
            w = owed[0];
            owed.delete(0);
            if (st !== w[115:113])
            begin
                $error("status exp %0d got %0d", w[115:113], st); errors++;
            end
            if (sp !== w[112:106])
            begin
                $error("start_position exp %0d got %0d", w[112:106], sp); errors++;
            end
            if (ep !== w[105:99])
            begin
                $error("end_position exp %0d got %0d", w[105:99], ep); errors++;
            end
            if (ts !== w[98:67])
            begin
                $error("out_timestamp exp %0h got %0h", w[98:67], ts); errors++;
            end
            if (lv !== w[66:64])
            begin
                $error("out_level exp %0d got %0d", w[66:64], lv); errors++;
            end
            if (pay !== w[63:0])
            begin
                $error("out_payload exp %0h got %0h", w[63:0], pay); errors++;
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic cfg_we = 0, cfg_index = 0;
    logic [toc_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 0, out_ready = 0;
    logic in_ready, out_valid;
    logic [2:0]  operation = '0;
    logic [31:0] timestamp = '0;
    logic [7:0]  level = '0;
    logic [63:0] payload = '0;
    logic [5:0]  position = '0;
    logic [2:0]  status, out_level;
    logic [6:0]  start_position, end_position;
    logic [31:0] out_timestamp;
    logic [63:0] out_payload;

    cache_scoreboard board = new();
    logic [31:0] clock_ts;   // newest fed timestamp, drives rising feeds
    bit          hold_sink;  // long receiver hold-off request
    int          cycles = 0;

    timestamp_ordered_ring_cache u_top (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Hang guard: the slowest legal run is far below this.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls per result, plus one long hold-off when asked.
    initial
    begin
        int gap;
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
            if (hold_sink && !held)
            begin
                held = 1;
                gap = 300;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_result(status, start_position, end_position, out_timestamp,
                               out_level, out_payload);
        end
    end

    task automatic write_reg(toc_pkg::cfg_idx_t idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[toc_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == toc_pkg::CFG_MAX_ENTRIES) board.max_ent = val & 32'h7F;
        else board.min_lvl = val & 32'h7;
    endtask

    // Send one request; hold valid until the block takes it.
    task automatic send(logic [2:0] op, logic [31:0] ts, logic [7:0] lv,
                        logic [63:0] pay, logic [5:0] pos, bit gaps);
        int gap;
        gap = 0;
        if (gaps && $urandom_range(0, 2) != 0) gap = $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1; operation <= op; timestamp <= ts; level <= lv;
        payload <= pay; position <= pos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(op, ts, lv, pay, pos);
    endtask

    // Wait until every owed result has come back, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic feed_next(logic [7:0] lv, bit gaps);
        clock_ts = clock_ts + 32'($urandom_range(1, 40));
        send(toc_pkg::OP_FEED, clock_ts, lv, {$urandom, $urandom}, '0, gaps);
    endtask

    // One random request, mostly well formed against the live records.
    task automatic random_request(bit gaps);
        int r;
        logic [31:0] t;
        logic [7:0] lv;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) lv = 8'($urandom_range(8, 255));
        else lv = 8'($urandom_range(0, 7));
        if (r < 40) feed_next(lv, gaps);
        else if (r < 45)
            send(toc_pkg::OP_FEED, clock_ts - $urandom_range(0, 5), 8'($urandom_range(0, 7)),
                 {$urandom, $urandom}, 6'($urandom), gaps);
        else if (r < 65)
        begin
            // Mostly hit a live timestamp, sometimes miss.
            if (board.count > 0 && $urandom_range(0, 3) != 0)
                t = board.stamps[board.slot_at($urandom_range(0, board.count - 1))];
            else
                t = $urandom;
            send(toc_pkg::OP_UPDATE, t, lv, {$urandom, $urandom}, 6'($urandom), gaps);
        end
        else if (r < 80)
            send(toc_pkg::OP_LATEST, $urandom, 8'($urandom_range(0, 8)), '0, '0, gaps);
        else if (r < 92)
            send(toc_pkg::OP_RANGE, $urandom, 8'($urandom_range(0, 8)), '0, '0, gaps);
        else if (r < 98)
            send(toc_pkg::OP_READ, $urandom, 8'($urandom), '0, 6'($urandom), gaps);
        else
            send(3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST)), $urandom,
                 8'($urandom), {$urandom, $urandom}, 6'($urandom), gaps);
    endtask

    initial
    begin
        board.clear();
        clock_ts = 0;
        hold_sink = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty-cache errors, bad levels, unknown codes.
        send(toc_pkg::OP_READ, 0, 0, 0, 0, 0);
        send(toc_pkg::OP_UPDATE, 5, 0, 0, 0, 0);
        send(toc_pkg::OP_LATEST, 0, 0, 0, 0, 0);
        send(toc_pkg::OP_FEED, 0, 8'hFF, '1, 0, 0);
        send(toc_pkg::OP_UPDATE, 0, 8'd8, 0, 0, 0);
        send(OP_UNKNOWN_FIRST, 0, 0, 0, 0, 0);
        send(OP_UNKNOWN_LAST, '1, '1, '1, '1, 0);
        // Extremes of timestamp and payload, non-rising and absent cases.
        send(toc_pkg::OP_FEED, 32'd0, 3'd7, 64'd0, 0, 0);
        send(toc_pkg::OP_FEED, 32'd0, 3'd1, '1, 0, 0);
        send(toc_pkg::OP_FEED, 32'h7FFF_FFFF, 3'd0, 64'hA5A5_5A5A_F0F0_0F0F, 0, 0);
        send(toc_pkg::OP_UPDATE, 32'h7FFF_FFFF, 3'd2, '1, 0, 0);
        send(toc_pkg::OP_UPDATE, 32'h1234, 3'd2, '1, 0, 0);
        send(toc_pkg::OP_RANGE, 0, 3'd1, 0, 0, 0);
        send(toc_pkg::OP_RANGE, 0, 3'd7, 0, 0, 0);
        send(toc_pkg::OP_LATEST, 0, 3'd0, 0, 0, 0);
        send(toc_pkg::OP_READ, 0, 0, 0, 6'd2, 0);
        send(toc_pkg::OP_READ, 0, 0, 0, 6'd63, 0);
        drain();

        // Tiny cache with strict eviction.
        write_reg(toc_pkg::CFG_MAX_ENTRIES, 0);
        write_reg(toc_pkg::CFG_EVICT_MIN, 7);
        clock_ts = 0;
        send(toc_pkg::OP_READ, 0, 0, 0, 0, 0);
        drain();
        // Free eviction; the feed below is non-rising against the newest stamp.
        write_reg(toc_pkg::CFG_EVICT_MIN, 0);
        send(toc_pkg::OP_FEED, 32'd5, 3'd0, 64'd9, 0, 0);
        drain();

        // Phases over configuration settings; timestamps continue from the newest one.
        for (int ph = 0; ph < 6; ph++)
        begin
            int unsigned me, ml;
            if (ph < 5)
            begin
                me = ME_SET[ph];
                ml = ML_SET[ph];
            end
            else
            begin
                me = $urandom_range(2, 64);
                ml = $urandom_range(0, 7);
            end
            write_reg(toc_pkg::CFG_MAX_ENTRIES, me);
            write_reg(toc_pkg::CFG_EVICT_MIN, ml);
            if (board.count > 0) clock_ts = board.stamps[board.slot_at(board.count - 1)];
            for (int k = 0; k < 130; k++)
            begin
                if (ph == 2 && k == 40) hold_sink = 1;
                random_request(!(ph == 1 && k < 30));
            end
            if (ph == 3) drain(); // sender pauses until all results are in
            drain();
        end

        // Top timestamp last: once stored, no later feed can rise above it.
        send(toc_pkg::OP_FEED, '1, 3'd3, 64'd1, 0, 0);
        send(toc_pkg::OP_FEED, '1, 3'd3, 64'd1, 0, 0);
        drain();

        if (board.errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

@@ sim.f @@
design/toc_pkg.sv
design/toc_ram.sv
design/timestamp_ordered_ring_cache.sv
tb/tb_top.sv
